// ----- hdl/aidr_pkg.sv -----
`timescale 1ns / 1ps

package aidr_pkg;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_REVERSE = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned COUNT_W = 8;

endpackage

// ----- hdl/array_insert_delete_reverse_core.sv -----
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in       in_valid / in_ready  operation, position, value
// out      out_valid / out_ready read_value, entry_count, status
//
// Insert moves the entries from position on up by one and writes the value;
// delete moves the entries above position down by one; reverse swaps pairs,
// low entry then high. The single write port of the entry RAM sets the pace.
// Reset clears the count and the control; RAM contents are not cleared.
// in_ready is high whenever the sequencer is idle, also while a result waits
// for out_ready; a finished item then waits in its last step.
module array_insert_delete_reverse_core #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          operation,
    input  logic [aidr_pkg::POS_W-1:0]          position,
    input  logic signed [aidr_pkg::WORD_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [aidr_pkg::WORD_W-1:0]  read_value,
    output logic [aidr_pkg::COUNT_W-1:0]        entry_count,
    output logic [1:0]                          status
);

    localparam int unsigned AW   = $clog2(CAPACITY);
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW > aidr_pkg::COUNT_W) ? CW : aidr_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_LAST,
        S_DEL,
        S_RV_LO,
        S_RV_HI,
        S_RD,
        S_DONE
    } state_t;

    state_t                        state_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [AW-1:0]                 pos_reg;
    logic [aidr_pkg::WORD_W-1:0]   val_reg;
    logic [AW-1:0]                 src_reg;   // moving source; low pointer on reverse
    logic [AW-1:0]                 hi_reg;
    logic [aidr_pkg::WORD_W-1:0]   res_val_reg;
    aidr_pkg::status_t             res_st_reg;
    logic                          out_valid_reg;
    logic [aidr_pkg::WORD_W-1:0]   out_val_reg;
    logic [aidr_pkg::COUNT_W-1:0]  out_cnt_reg;
    aidr_pkg::status_t             out_st_reg;

    logic                          ram_we;
    logic [AW-1:0]                 ram_wa;
    logic [aidr_pkg::WORD_W-1:0]   ram_wd;
    logic                          ram_re;
    logic [AW-1:0]                 ram_ra_a;
    logic [AW-1:0]                 ram_ra_b;
    logic [aidr_pkg::WORD_W-1:0]   rd_a;
    logic [aidr_pkg::WORD_W-1:0]   rd_b;

    logic [CMPW-1:0]               pos_ext;
    logic [CMPW-1:0]               cnt_ext;
    logic [AW-1:0]                 pos_aw;
    logic [AW-1:0]                 cnt_m1;
    logic                          full;

    assign pos_ext = CMPW'(position);
    assign cnt_ext = CMPW'(cnt_reg);
    assign pos_aw  = AW'(position);
    assign cnt_m1  = AW'(cnt_reg - CW'(1));
    assign full    = (cnt_reg == CW'(CAPACITY));

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign read_value  = out_val_reg;
    assign entry_count = out_cnt_reg;
    assign status      = out_st_reg;

    aidr_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .wa   (ram_wa),
        .wd   (ram_wd),
        .re   (ram_re),
        .ra_a (ram_ra_a),
        .ra_b (ram_ra_b),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    // RAM port steering; reads are issued ahead of the write that uses their registered data
    always_comb
    begin
        ram_we   = 1'b0;
        ram_wa   = src_reg;
        ram_wd   = rd_a;
        ram_re   = 1'b0;
        ram_ra_a = src_reg;
        ram_ra_b = hi_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_re = in_valid;
                unique case (aidr_pkg::op_t'(operation))
                    aidr_pkg::OP_INSERT:  ram_ra_a = cnt_m1;
                    aidr_pkg::OP_DELETE:  ram_ra_a = pos_aw + AW'(1);
                    aidr_pkg::OP_REVERSE:
                    begin
                        ram_ra_a = '0;
                        ram_ra_b = cnt_m1;
                    end
                    aidr_pkg::OP_READ:    ram_ra_a = pos_aw;
                endcase
            end
            S_INS:
            begin
                ram_we   = 1'b1;
                ram_wa   = src_reg + AW'(1);
                ram_re   = 1'b1;
                ram_ra_a = src_reg - AW'(1);
            end
            S_INS_LAST:
            begin
                ram_we = 1'b1;
                ram_wa = pos_reg;
                ram_wd = val_reg;
            end
            S_DEL:
            begin
                ram_we   = 1'b1;
                ram_wa   = src_reg - AW'(1);
                ram_re   = 1'b1;
                ram_ra_a = src_reg + AW'(1);
            end
            S_RV_LO:
            begin
                ram_we = 1'b1;
                ram_wa = src_reg;
                ram_wd = rd_b;
            end
            S_RV_HI:
            begin
                ram_we   = 1'b1;
                ram_wa   = hi_reg;
                ram_re   = 1'b1;
                ram_ra_a = src_reg + AW'(1);
                ram_ra_b = hi_reg - AW'(1);
            end
            S_RD, S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            val_reg       <= '0;
            src_reg       <= '0;
            hi_reg        <= '0;
            res_val_reg   <= '0;
            res_st_reg    <= aidr_pkg::ST_OK;
            out_valid_reg <= 1'b0;
            out_val_reg   <= '0;
            out_cnt_reg   <= '0;
            out_st_reg    <= aidr_pkg::ST_OK;
        end
        else
        begin
            // S_DONE handles the output register on its own
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        pos_reg     <= pos_aw;
                        val_reg     <= value;
                        res_val_reg <= '0;
                        res_st_reg  <= aidr_pkg::ST_OK;
                        unique case (aidr_pkg::op_t'(operation))
                            aidr_pkg::OP_INSERT:
                            begin
                                priority if (full)
                                begin
                                    res_st_reg <= aidr_pkg::ST_FULL;
                                    state_reg  <= S_DONE;
                                end
                                else if (pos_ext > cnt_ext)
                                begin
                                    res_st_reg <= aidr_pkg::ST_RANGE;
                                    state_reg  <= S_DONE;
                                end
                                else if (pos_ext == cnt_ext)
                                begin
                                    state_reg <= S_INS_LAST;
                                end
                                else
                                begin
                                    src_reg   <= cnt_m1;
                                    state_reg <= S_INS;
                                end
                            end
                            aidr_pkg::OP_DELETE:
                            begin
                                priority if (pos_ext >= cnt_ext)
                                begin
                                    res_st_reg <= aidr_pkg::ST_RANGE;
                                    state_reg  <= S_DONE;
                                end
                                else if (pos_ext + CMPW'(1) == cnt_ext)
                                begin
                                    // last entry: nothing to move
                                    cnt_reg   <= cnt_reg - CW'(1);
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    src_reg   <= pos_aw + AW'(1);
                                    state_reg <= S_DEL;
                                end
                            end
                            aidr_pkg::OP_REVERSE:
                            begin
                                if (cnt_reg < CW'(2))
                                begin
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    src_reg   <= '0;
                                    hi_reg    <= cnt_m1;
                                    state_reg <= S_RV_LO;
                                end
                            end
                            aidr_pkg::OP_READ:
                            begin
                                if (pos_ext >= cnt_ext)
                                begin
                                    res_st_reg <= aidr_pkg::ST_RANGE;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_RD;
                                end
                            end
                        endcase
                    end
                end
                S_INS:
                begin
                    src_reg <= src_reg - AW'(1);
                    if (src_reg == pos_reg)
                    begin
                        state_reg <= S_INS_LAST;
                    end
                end
                S_INS_LAST:
                begin
                    cnt_reg   <= cnt_reg + CW'(1);
                    state_reg <= S_DONE;
                end
                S_DEL:
                begin
                    src_reg <= src_reg + AW'(1);
                    if (src_reg == cnt_m1)
                    begin
                        cnt_reg   <= cnt_reg - CW'(1);
                        state_reg <= S_DONE;
                    end
                end
                S_RV_LO:
                begin
                    state_reg <= S_RV_HI;
                end
                S_RV_HI:
                begin
                    src_reg <= src_reg + AW'(1);
                    hi_reg  <= hi_reg - AW'(1);
                    // another pair remains while lo + 1 < hi - 1
                    if ({1'b0, src_reg} + (AW+1)'(2) < {1'b0, hi_reg})
                    begin
                        state_reg <= S_RV_LO;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_RD:
                begin
                    res_val_reg <= rd_a;
                    state_reg   <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_val_reg   <= res_val_reg;
                        out_cnt_reg   <= aidr_pkg::COUNT_W'(cnt_reg);
                        out_st_reg    <= res_st_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/aidr_ram.sv -----
`timescale 1ns / 1ps

// One write port, two registered read ports sharing one read enable.
// Read data holds while the enable is low.
module aidr_ram #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [AW-1:0]                  wa,
    input  logic [aidr_pkg::WORD_W-1:0]    wd,
    input  logic                           re,
    input  logic [AW-1:0]                  ra_a,
    input  logic [AW-1:0]                  ra_b,
    output logic [aidr_pkg::WORD_W-1:0]    rd_a,
    output logic [aidr_pkg::WORD_W-1:0]    rd_b
);

    logic [aidr_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_a <= mem[ra_a];
            rd_b <= mem[ra_b];
        end
    end

endmodule
